// File: sv/ssp_pkg.sv
`timescale 1ns / 1ps

package ssp_pkg;

  localparam int NODE_W   = 10;
  localparam int CFG_W    = 11;
  localparam int WEIGHT_W = 16;
  localparam int DIST_W   = 32;

  typedef enum logic [1:0] {
    MODE_CLEAR = 2'd0,
    MODE_ADD   = 2'd1,
    MODE_RUN   = 2'd2,
    MODE_READ  = 2'd3
  } mode_t;

  typedef enum logic {
    KIND_RUN  = 1'b0,
    KIND_READ = 1'b1
  } kind_t;

  typedef struct packed {
    logic [1:0]                 mode;
    logic [NODE_W-1:0]          src_node;
    logic [NODE_W-1:0]          dst_node;
    logic signed [WEIGHT_W-1:0] weight;
  } item_t;

  typedef struct packed {
    logic                     kind;
    logic                     negative_cycle;
    logic                     edges_dropped;
    logic [NODE_W-1:0]        node_index;
    logic                     reachable;
    logic signed [DIST_W-1:0] distance;
  } result_t;

  typedef struct packed {
    logic                     reach;
    logic signed [DIST_W-1:0] value;
  } dist_t;

  typedef struct packed {
    logic                     relax;
    logic signed [DIST_W-1:0] cand;
  } relax_t;

endpackage

// File: sv/ssp_stream_if.sv
`timescale 1ns / 1ps

interface ssp_item_if;
  logic           valid;
  logic           ready;
  ssp_pkg::item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface ssp_result_if;
  logic             valid;
  logic             ready;
  ssp_pkg::result_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// File: sv/ssp_ram.sv
`timescale 1ns / 1ps

module ssp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: sv/ssp_relax.sv
`timescale 1ns / 1ps

module ssp_relax #(
  parameter int WB = 16
) (
  input  logic                  clk,
  input  ssp_pkg::dist_t        tail_dist,
  input  ssp_pkg::dist_t        head_dist,
  input  logic signed [WB-1:0]  weight,
  output ssp_pkg::relax_t       res
);

  localparam int DW = ssp_pkg::DIST_W;
  localparam int SW = DW + 2;
  localparam logic signed [DW-1:0] DHI = {1'b0, {(DW-1){1'b1}}};
  localparam logic signed [DW-1:0] DLO = {1'b1, {(DW-1){1'b0}}};

  logic signed [SW-1:0] tail_ext;
  logic signed [SW-1:0] w_ext;
  logic signed [SW-1:0] sum;
  logic signed [DW-1:0] cand;

  always_comb begin
    tail_ext = SW'(tail_dist.value);
    w_ext    = SW'(weight);
    sum      = tail_ext + w_ext;
    if (sum > SW'(DHI)) begin
      cand = DHI;
    end else if (sum < SW'(DLO)) begin
      cand = DLO;
    end else begin
      cand = DW'(sum);
    end
  end

  always_ff @(posedge clk) begin
    res.cand  <= cand;
    res.relax <= !head_dist.reach || (cand < head_dist.value);
  end

endmodule

// File: sv/single_source_shortest_paths.sv
`timescale 1ns / 1ps

// Bellman-Ford shortest paths over a stored edge list. Clear and add beats are taken one per
// cycle while idle; a distance read goes to S_EMIT, through S_RD_WAIT for an in-range node
// after a run. A run is a sequence over four simple dual-port memories, one step at a time:
// a pass over all MAX_NODES entries to mark every distance unreachable, then, for an in-range
// source, its seed at zero, a counting sort of the usable edges by tail node (counting, prefix
// sums, scatter), n - 1 relaxation rounds and one checking round, n being the clamped
// node_count. Each edge reads its tail and, if that is reachable, its head distance through
// the single read port, and a relaxing round writes any improvement back before the next edge
// starts. No clearing pass follows reset: until the first run, every node reads as unreachable.
// A finished result waits in an output register, and new beats are taken while it does.
module single_source_shortest_paths #(
  parameter int MAX_NODES   = 1024,
  parameter int MAX_EDGES   = 4096,
  parameter int WEIGHT_BITS = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_wr_en,
  input  logic [ssp_pkg::CFG_W-1:0]  cfg_wr_data,
  ssp_item_if.sink                   items,
  ssp_result_if.source               results
);

  localparam int NODE_W = ssp_pkg::NODE_W;
  localparam int NCW    = $clog2(MAX_NODES + 1);
  localparam int NW     = $clog2(MAX_NODES);
  localparam int CAW    = $clog2(MAX_NODES + 1);
  localparam int ETW    = $clog2(MAX_EDGES + 1);
  localparam int EAW    = $clog2(MAX_EDGES);
  localparam int EW     = 2 * NODE_W + WEIGHT_BITS;
  localparam int DTW    = $bits(ssp_pkg::dist_t);

  typedef enum logic [4:0] {
    S_IDLE, S_CLR, S_SEED, S_CCLR, S_CNT_RD, S_CNT_WAIT, S_CNT_INC, S_PFX_RD, S_PFX_WR,
    S_SCT_RD, S_SCT_WAIT, S_SCT_WR, S_EDGE_RD, S_EDGE_WAIT, S_DA, S_DB, S_UPD, S_RD_WAIT,
    S_EMIT
  } state_t;

  state_t                     state;
  logic [ssp_pkg::CFG_W-1:0]  node_count;
  logic [ETW-1:0]             edge_total;
  logic                       dropped;
  logic                       dist_valid;
  logic                       out_valid;
  ssp_pkg::result_t           out_item;
  logic                       checking;
  logic [ETW-1:0]             i;
  logic [ETW-1:0]             j;
  logic [ETW-1:0]             usable;
  logic [ETW-1:0]             acc;
  logic [NCW-1:0]             k;
  logic [NCW-1:0]             r;
  logic [EW-1:0]              cur_edge;
  ssp_pkg::dist_t             tail_dist;
  ssp_pkg::kind_t             res_kind;
  logic                       res_neg;
  logic [NODE_W-1:0]          res_node;
  logic                       res_reach;
  logic signed [31:0]         res_dist;

  logic [NCW-1:0]             n;
  logic                       src_ok;
  logic                       store_full;
  logic [31:0]                raw_weight;
  logic [EW-1:0]              in_edge;
  logic [NODE_W-1:0]          e_tail;
  logic [NODE_W-1:0]          e_head;
  logic                       edge_ok;
  logic [NODE_W-1:0]          s_tail;
  logic [NODE_W-1:0]          cur_tail;
  logic [NODE_W-1:0]          cur_head;
  logic signed [WEIGHT_BITS-1:0] cur_w;
  logic [ETW-1:0]             acc_sum;

  logic                       edge_we;
  logic [EAW-1:0]             edge_waddr;
  logic [EAW-1:0]             edge_raddr;
  logic [EW-1:0]              edge_rdata;
  logic                       sort_we;
  logic [EAW-1:0]             sort_waddr;
  logic [EAW-1:0]             sort_raddr;
  logic [EW-1:0]              sort_rdata;
  logic                       cnt_we;
  logic [CAW-1:0]             cnt_waddr;
  logic [ETW-1:0]             cnt_wdata;
  logic [CAW-1:0]             cnt_raddr;
  logic [ETW-1:0]             cnt_rdata;
  logic                       dist_we;
  logic [NW-1:0]              dist_waddr;
  ssp_pkg::dist_t             dist_wdata;
  logic [NW-1:0]              dist_raddr;
  ssp_pkg::dist_t             dist_rdata;
  ssp_pkg::relax_t            relax_res;

  always_comb begin
    if (node_count == '0) begin
      n = NCW'(1);
    end else if (32'(node_count) > MAX_NODES) begin
      n = NCW'(MAX_NODES);
    end else begin
      n = NCW'(node_count);
    end
  end

  assign src_ok     = 32'(items.payload.src_node) < 32'(n);
  assign store_full = 32'(edge_total) >= MAX_EDGES;
  assign raw_weight = {{(32 - ssp_pkg::WEIGHT_W){1'b0}}, items.payload.weight};
  assign in_edge    = {items.payload.src_node, items.payload.dst_node,
                       raw_weight[WEIGHT_BITS-1:0]};
  assign e_tail     = edge_rdata[EW-1 -: NODE_W];
  assign e_head     = edge_rdata[WEIGHT_BITS +: NODE_W];
  assign edge_ok    = (32'(e_tail) < 32'(n)) && (32'(e_head) < 32'(n));
  assign s_tail     = sort_rdata[EW-1 -: NODE_W];
  assign cur_tail   = cur_edge[EW-1 -: NODE_W];
  assign cur_head   = cur_edge[WEIGHT_BITS +: NODE_W];
  assign cur_w      = cur_edge[WEIGHT_BITS-1:0];
  assign acc_sum    = acc + cnt_rdata;

  assign items.ready     = (state == S_IDLE);
  assign results.valid   = out_valid;
  assign results.payload = out_item;

  always_comb begin
    edge_we    = 1'b0;
    edge_waddr = edge_total[EAW-1:0];
    edge_raddr = i[EAW-1:0];
    sort_we    = 1'b0;
    sort_waddr = cnt_rdata[EAW-1:0];
    sort_raddr = j[EAW-1:0];
    cnt_we     = 1'b0;
    cnt_waddr  = k[CAW-1:0];
    cnt_wdata  = '0;
    cnt_raddr  = k[CAW-1:0];
    dist_we    = 1'b0;
    dist_waddr = k[NW-1:0];
    dist_wdata = '0;
    dist_raddr = NW'(items.payload.src_node);
    case (state)
      S_IDLE: begin
        edge_we = items.valid && (items.payload.mode == ssp_pkg::MODE_ADD) && !store_full;
      end
      S_CLR: begin
        dist_we = 1'b1;
      end
      S_SEED: begin
        dist_we    = 1'b1;
        dist_waddr = NW'(res_node);
        dist_wdata = '{reach: 1'b1, value: '0};
      end
      S_CCLR: begin
        cnt_we = 1'b1;
      end
      S_CNT_WAIT: begin
        cnt_raddr = CAW'(e_tail) + CAW'(1);
      end
      S_CNT_INC: begin
        cnt_we    = 1'b1;
        cnt_waddr = CAW'(cur_tail) + CAW'(1);
        cnt_wdata = cnt_rdata + ETW'(1);
      end
      S_PFX_WR: begin
        cnt_we    = 1'b1;
        cnt_wdata = acc_sum;
      end
      S_SCT_WAIT: begin
        cnt_raddr = CAW'(e_tail);
      end
      S_SCT_WR: begin
        cnt_we    = 1'b1;
        cnt_waddr = CAW'(cur_tail);
        cnt_wdata = cnt_rdata + ETW'(1);
        sort_we   = 1'b1;
      end
      S_EDGE_WAIT: begin
        dist_raddr = NW'(s_tail);
      end
      S_DA: begin
        dist_raddr = NW'(cur_head);
      end
      S_UPD: begin
        dist_we    = relax_res.relax && !checking;
        dist_waddr = NW'(cur_head);
        dist_wdata = '{reach: 1'b1, value: relax_res.cand};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      node_count <= ssp_pkg::CFG_W'(1);
      edge_total <= '0;
      dropped    <= 1'b0;
      dist_valid <= 1'b0;
      out_valid  <= 1'b0;
      checking   <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        node_count <= cfg_wr_data;
      end
      if (results.ready && state != S_EMIT) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (items.valid) begin
            res_node <= items.payload.src_node;
            res_neg  <= 1'b0;
            res_dist <= '0;
            case (ssp_pkg::mode_t'(items.payload.mode))
              ssp_pkg::MODE_CLEAR: begin
                edge_total <= '0;
                dropped    <= 1'b0;
              end
              ssp_pkg::MODE_ADD: begin
                if (store_full) begin
                  dropped <= 1'b1;
                end else begin
                  edge_total <= edge_total + ETW'(1);
                end
              end
              ssp_pkg::MODE_RUN: begin
                res_kind  <= ssp_pkg::KIND_RUN;
                res_reach <= src_ok;
                k         <= '0;
                state     <= S_CLR;
              end
              ssp_pkg::MODE_READ: begin
                res_kind  <= ssp_pkg::KIND_READ;
                res_reach <= 1'b0;
                state     <= (src_ok && dist_valid) ? S_RD_WAIT : S_EMIT;
              end
              default: begin
              end
            endcase
          end
        end
        S_RD_WAIT: begin
          res_reach <= dist_rdata.reach;
          res_dist  <= dist_rdata.reach ? dist_rdata.value : '0;
          state     <= S_EMIT;
        end
        S_CLR: begin
          k <= k + NCW'(1);
          if (k == NCW'(MAX_NODES - 1)) begin
            dist_valid <= 1'b1;
            state      <= res_reach ? S_SEED : S_EMIT;
          end
        end
        S_SEED: begin
          k     <= '0;
          state <= S_CCLR;
        end
        S_CCLR: begin
          if (k == n) begin
            i     <= '0;
            state <= S_CNT_RD;
          end else begin
            k <= k + NCW'(1);
          end
        end
        S_CNT_RD: begin
          if (i == edge_total) begin
            k     <= '0;
            acc   <= '0;
            state <= S_PFX_RD;
          end else begin
            state <= S_CNT_WAIT;
          end
        end
        S_CNT_WAIT: begin
          cur_edge <= edge_rdata;
          if (edge_ok) begin
            state <= S_CNT_INC;
          end else begin
            i     <= i + ETW'(1);
            state <= S_CNT_RD;
          end
        end
        S_CNT_INC: begin
          i     <= i + ETW'(1);
          state <= S_CNT_RD;
        end
        S_PFX_RD: begin
          state <= S_PFX_WR;
        end
        S_PFX_WR: begin
          acc <= acc_sum;
          if (k == n) begin
            i      <= '0;
            usable <= '0;
            state  <= S_SCT_RD;
          end else begin
            k     <= k + NCW'(1);
            state <= S_PFX_RD;
          end
        end
        S_SCT_RD: begin
          if (i == edge_total) begin
            j        <= '0;
            r        <= '0;
            checking <= (n == NCW'(1));
            state    <= S_EDGE_RD;
          end else begin
            state <= S_SCT_WAIT;
          end
        end
        S_SCT_WAIT: begin
          cur_edge <= edge_rdata;
          if (edge_ok) begin
            state <= S_SCT_WR;
          end else begin
            i     <= i + ETW'(1);
            state <= S_SCT_RD;
          end
        end
        S_SCT_WR: begin
          usable <= usable + ETW'(1);
          i      <= i + ETW'(1);
          state  <= S_SCT_RD;
        end
        S_EDGE_RD: begin
          if (j == usable) begin
            if (checking) begin
              state <= S_EMIT;
            end else begin
              j <= '0;
              r <= r + NCW'(1);
              if (r + NCW'(1) == n - NCW'(1)) begin
                checking <= 1'b1;
              end
            end
          end else begin
            state <= S_EDGE_WAIT;
          end
        end
        S_EDGE_WAIT: begin
          cur_edge <= sort_rdata;
          state    <= S_DA;
        end
        S_DA: begin
          tail_dist <= dist_rdata;
          if (dist_rdata.reach) begin
            state <= S_DB;
          end else begin
            j     <= j + ETW'(1);
            state <= S_EDGE_RD;
          end
        end
        S_DB: begin
          state <= S_UPD;
        end
        S_UPD: begin
          if (relax_res.relax && checking) begin
            res_neg <= 1'b1;
            state   <= S_EMIT;
          end else begin
            j     <= j + ETW'(1);
            state <= S_EDGE_RD;
          end
        end
        S_EMIT: begin
          if (!out_valid || results.ready) begin
            out_valid               <= 1'b1;
            out_item.kind           <= res_kind;
            out_item.negative_cycle <= res_neg;
            out_item.edges_dropped  <= dropped;
            out_item.node_index     <= res_node;
            out_item.reachable      <= res_reach;
            out_item.distance       <= res_dist;
            state                   <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  ssp_ram #(.WIDTH(EW), .DEPTH(MAX_EDGES)) u_edge_ram (
    .clk   (clk),
    .we    (edge_we),
    .waddr (edge_waddr),
    .wdata (in_edge),
    .raddr (edge_raddr),
    .rdata (edge_rdata)
  );

  ssp_ram #(.WIDTH(EW), .DEPTH(MAX_EDGES)) u_sort_ram (
    .clk   (clk),
    .we    (sort_we),
    .waddr (sort_waddr),
    .wdata (cur_edge),
    .raddr (sort_raddr),
    .rdata (sort_rdata)
  );

  ssp_ram #(.WIDTH(ETW), .DEPTH(MAX_NODES + 1)) u_cnt_ram (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (cnt_waddr),
    .wdata (cnt_wdata),
    .raddr (cnt_raddr),
    .rdata (cnt_rdata)
  );

  ssp_ram #(.WIDTH(DTW), .DEPTH(MAX_NODES)) u_dist_ram (
    .clk   (clk),
    .we    (dist_we),
    .waddr (dist_waddr),
    .wdata (dist_wdata),
    .raddr (dist_raddr),
    .rdata (dist_rdata)
  );

  ssp_relax #(.WB(WEIGHT_BITS)) u_relax (
    .clk       (clk),
    .tail_dist (tail_dist),
    .head_dist (dist_rdata),
    .weight    (cur_w),
    .res       (relax_res)
  );

  assert property (@(posedge clk) disable iff (rst)
    32'(edge_total) <= MAX_EDGES)
    else $error("Edge count exceeds the store capacity.");

  assert property (@(posedge clk) disable iff (rst)
    items.valid && items.ready && items.payload.mode == ssp_pkg::MODE_CLEAR
    |=> edge_total == '0 && !dropped)
    else $error("Clear beat did not empty the edge store.");

  assert property (@(posedge clk) disable iff (rst)
    state == S_EDGE_RD |-> usable <= edge_total)
    else $error("Sorted edge count exceeds the stored edge count.");

  assert property (@(posedge clk) disable iff (rst)
    !$past(out_valid) && out_valid |-> $past(state == S_EMIT))
    else $error("Result register loaded outside the emit step.");

  assert property (@(posedge clk) disable iff (rst)
    state == S_UPD && checking && relax_res.relax |=> state == S_EMIT && res_neg)
    else $error("Relaxable edge in the checking round was not reported.");

endmodule

// File: tb/sv/ssp_path_checker.sv
`timescale 1ns / 1ps

module ssp_path_checker
  import ssp_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_wr_en,
  input  logic [CFG_W-1:0] cfg_wr_data,
  ssp_item_if              items,
  ssp_result_if            results,
  output int               mismatch_count,
  output int               reports_owed
);

  localparam int NODE_SLOTS = 1024;
  localparam int EDGE_SLOTS = 4096;
  localparam longint DIST_HI = (64'sd1 <<< (DIST_W - 1)) - 1;
  localparam longint DIST_LO = -(64'sd1 <<< (DIST_W - 1));

  logic [NODE_W-1:0]          tail_mem [EDGE_SLOTS];
  logic [NODE_W-1:0]          head_mem [EDGE_SLOTS];
  logic signed [WEIGHT_W-1:0] wt_mem [EDGE_SLOTS];
  int unsigned                edge_fill;
  bit                         lost_edge;
  bit                         reach_tab [NODE_SLOTS];
  logic signed [DIST_W-1:0]   dist_tab [NODE_SLOTS];
  logic [CFG_W-1:0]           nodes_cfg;
  int                         sorted_edges [EDGE_SLOTS];
  int                         bucket [NODE_SLOTS+1];
  result_t                    awaited_reports [$];

  function automatic int unsigned live_nodes();
    if (nodes_cfg == 0) return 1;
    if (nodes_cfg > NODE_SLOTS) return NODE_SLOTS;
    return int'(nodes_cfg);
  endfunction

  function automatic logic signed [DIST_W-1:0] add_clamped(
    input logic signed [DIST_W-1:0]   base,
    input logic signed [WEIGHT_W-1:0] step
  );
    longint total;
    total = longint'(base) + longint'(step);
    if (total > DIST_HI) total = DIST_HI;
    else if (total < DIST_LO) total = DIST_LO;
    return total[DIST_W-1:0];
  endfunction

  function automatic bit edge_improves(input int e, output logic signed [DIST_W-1:0] cand);
    cand = '0;
    if (!reach_tab[tail_mem[e]]) return 1'b0;
    cand = add_clamped(dist_tab[tail_mem[e]], wt_mem[e]);
    return !reach_tab[head_mem[e]] || (cand < dist_tab[head_mem[e]]);
  endfunction

  // Returns whether some edge can still be relaxed after the last round.
  function automatic bit relax_from(input int unsigned origin, input int unsigned n);
    int unsigned usable;
    int unsigned r;
    int unsigned j;
    int unsigned e;
    int unsigned k;
    logic signed [DIST_W-1:0] cand;
    for (j = 0; j < NODE_SLOTS; j++) begin
      reach_tab[j] = 1'b0;
      dist_tab[j] = '0;
    end
    if (origin >= n) return 1'b0;
    reach_tab[origin] = 1'b1;
    for (k = 0; k <= NODE_SLOTS; k++) bucket[k] = 0;
    for (e = 0; e < edge_fill; e++) begin
      if (tail_mem[e] < n && head_mem[e] < n) bucket[tail_mem[e] + 1]++;
    end
    for (k = 0; k < n; k++) bucket[k + 1] += bucket[k];
    usable = 0;
    for (e = 0; e < edge_fill; e++) begin
      if (tail_mem[e] < n && head_mem[e] < n) begin
        sorted_edges[bucket[tail_mem[e]]] = int'(e);
        bucket[tail_mem[e]]++;
        usable++;
      end
    end
    for (r = 0; r + 1 < n; r++) begin
      for (j = 0; j < usable; j++) begin
        if (edge_improves(sorted_edges[j], cand)) begin
          reach_tab[head_mem[sorted_edges[j]]] = 1'b1;
          dist_tab[head_mem[sorted_edges[j]]] = cand;
        end
      end
    end
    for (j = 0; j < usable; j++) begin
      if (edge_improves(sorted_edges[j], cand)) return 1'b1;
    end
    return 1'b0;
  endfunction

  task automatic queue_report(input result_t rep);
    awaited_reports = {awaited_reports, rep};
  endtask

  task automatic compare_field(input string label, input logic signed [63:0] want,
                               input logic signed [63:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0d, got %0d", label, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin
    item_t       beat;
    result_t     want;
    result_t     got;
    int unsigned n;
    if (rst) begin
      nodes_cfg = CFG_W'(1);
      edge_fill = 0;
      lost_edge = 1'b0;
      for (int j = 0; j < NODE_SLOTS; j++) begin
        reach_tab[j] = 1'b0;
        dist_tab[j] = '0;
      end
      awaited_reports.delete();
      mismatch_count = 0;
    end else begin
      if (cfg_wr_en) nodes_cfg = cfg_wr_data;
      if (results.valid && results.ready) begin
        got = results.payload;
        if (awaited_reports.size() == 0) begin
          $error("result beat %h arrived with no result pending", got);
          mismatch_count++;
        end else begin
          want = awaited_reports.pop_front();
          compare_field("kind", want.kind, got.kind);
          compare_field("negative_cycle", want.negative_cycle, got.negative_cycle);
          compare_field("edges_dropped", want.edges_dropped, got.edges_dropped);
          compare_field("node_index", want.node_index, got.node_index);
          compare_field("reachable", want.reachable, got.reachable);
          compare_field("distance", want.distance, got.distance);
        end
      end
      if (items.valid && items.ready) begin
        beat = items.payload;
        n = live_nodes();
        case (beat.mode)
          MODE_CLEAR: begin
            edge_fill = 0;
            lost_edge = 1'b0;
          end
          MODE_ADD: begin
            if (edge_fill < EDGE_SLOTS) begin
              tail_mem[edge_fill] = beat.src_node;
              head_mem[edge_fill] = beat.dst_node;
              wt_mem[edge_fill] = beat.weight;
              edge_fill++;
            end else begin
              lost_edge = 1'b1;
            end
          end
          MODE_RUN: begin
            want.kind = KIND_RUN;
            want.negative_cycle = relax_from(beat.src_node, n);
            want.edges_dropped = lost_edge;
            want.node_index = beat.src_node;
            want.reachable = beat.src_node < n;
            want.distance = '0;
            queue_report(want);
          end
          default: begin
            want.kind = KIND_READ;
            want.negative_cycle = 1'b0;
            want.edges_dropped = lost_edge;
            want.node_index = beat.src_node;
            want.reachable = (beat.src_node < n) && reach_tab[beat.src_node];
            want.distance = want.reachable ? dist_tab[beat.src_node] : '0;
            queue_report(want);
          end
        endcase
      end
    end
    reports_owed = awaited_reports.size();
  end

endmodule

// File: tb/sv/tb_single_source_shortest_paths.sv
`timescale 1ns / 1ps

module tb_single_source_shortest_paths;
  import ssp_pkg::*;

  localparam int RANDOM_ITEMS = 1800;
  localparam int SETTLE_CYCLES = 32;
  localparam int END_CYCLES = 64;
  localparam int LONG_HOLD = 400;
  localparam int QUIET_LIMIT = 2000000;
  localparam logic signed [WEIGHT_W-1:0] W_MIN = 16'h8000;
  localparam logic signed [WEIGHT_W-1:0] W_MAX = 16'h7FFF;

  logic             clk = 1'b0;
  logic             rst;
  logic             cfg_wr_en;
  logic [CFG_W-1:0] cfg_wr_data;
  bit               steady;
  bit               long_hold;
  int               live;
  int               quiet_cycles;
  int               mismatch_count;
  int               reports_owed;

  ssp_item_if   items_bus ();
  ssp_result_if results_bus ();

  single_source_shortest_paths uut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .items       (items_bus),
    .results     (results_bus)
  );

  ssp_path_checker path_check (
    .clk            (clk),
    .rst            (rst),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .items          (items_bus),
    .results        (results_bus),
    .mismatch_count (mismatch_count),
    .reports_owed   (reports_owed)
  );

  always #2 clk = ~clk;

  function automatic logic [NODE_W-1:0] any_node();
    return NODE_W'($urandom_range(0, 1023));
  endfunction

  function automatic logic [NODE_W-1:0] pick_node(input int span);
    if ($urandom_range(0, 9) == 0) return any_node();
    return NODE_W'($urandom_range(0, span - 1));
  endfunction

  function automatic logic signed [WEIGHT_W-1:0] pick_weight();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: return WEIGHT_W'($urandom_range(0, 80) - 25);
      6, 7: return WEIGHT_W'($urandom);
      8: return $urandom_range(0, 1) ? W_MAX : W_MIN;
      default: return $urandom_range(0, 1) ? WEIGHT_W'(0) : WEIGHT_W'(-1);
    endcase
  endfunction

  task automatic send_item(input mode_t op, input logic [NODE_W-1:0] a,
                           input logic [NODE_W-1:0] b, input logic signed [WEIGHT_W-1:0] w);
    item_t beat;
    int    gap;
    beat.mode = op;
    beat.src_node = a;
    beat.dst_node = b;
    beat.weight = w;
    gap = steady ? 0 : $urandom_range(0, 7);
    @(negedge clk);
    if (gap != 0) begin
      items_bus.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    items_bus.valid <= 1'b1;
    items_bus.payload <= beat;
    @(posedge clk);
    while (!items_bus.ready) @(posedge clk);
  endtask

  task automatic drain();
    @(negedge clk);
    items_bus.valid <= 1'b0;
    while (reports_owed != 0) @(negedge clk);
  endtask

  // Adds and clears leave no result behind, so after the drain the task waits out a settle delay first.
  task automatic set_nodes(input logic [CFG_W-1:0] value);
    drain();
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    live = (value == 0) ? 1 : ((value > 1024) ? 1024 : int'(value));
  endtask

  always @(posedge clk) begin
    if (rst || (items_bus.valid && items_bus.ready) ||
        (results_bus.valid && results_bus.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  initial begin : result_side
    int hold;
    results_bus.ready = 1'b0;
    @(negedge clk);
    forever begin
      if (long_hold) begin
        hold = LONG_HOLD;
        long_hold = 1'b0;
      end else begin
        hold = steady ? 0 : $urandom_range(0, 7);
      end
      if (hold != 0) begin
        results_bus.ready <= 1'b0;
        repeat (hold) @(negedge clk);
      end
      results_bus.ready <= 1'b1;
      @(posedge clk);
      while (!results_bus.valid) @(posedge clk);
      @(negedge clk);
    end
  end

  initial begin : item_side
    int               k;
    int               count;
    int               sent;
    int               session;
    bit               big;
    logic [CFG_W-1:0] cfg_val;
    rst = 1'b1;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    items_bus.valid = 1'b0;
    items_bus.payload = '0;
    steady = 1'b0;
    long_hold = 1'b0;
    live = 1;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Nothing has run yet, so every node reads as unreachable until the run below.
    send_item(MODE_READ, 10'd0, 10'd0, 16'sd0);
    send_item(MODE_RUN, 10'd0, 10'd0, 16'sd0);
    send_item(MODE_READ, 10'd0, 10'd0, 16'sd0);
    send_item(MODE_READ, 10'd1023, 10'd0, 16'sd0);

    set_nodes(CFG_W'(0));
    send_item(MODE_RUN, 10'd5, 10'd0, 16'sd0);

    set_nodes(CFG_W'(4));
    send_item(MODE_CLEAR, 10'd0, 10'd0, 16'sd0);
    send_item(MODE_ADD, 10'd0, 10'd1, W_MAX);
    send_item(MODE_ADD, 10'd1, 10'd2, W_MIN);
    send_item(MODE_ADD, 10'd2, 10'd3, 16'sd5);
    send_item(MODE_ADD, 10'd3, 10'd1, 16'sd100);
    send_item(MODE_ADD, 10'd0, 10'd1023, -16'sd1);
    send_item(MODE_RUN, 10'd0, 10'd0, 16'sd0);
    for (k = 0; k < 4; k++) send_item(MODE_READ, NODE_W'(k), 10'd0, 16'sd0);

    set_nodes(CFG_W'(2047));
    send_item(MODE_CLEAR, 10'd0, 10'd0, 16'sd0);
    send_item(MODE_ADD, 10'd0, 10'd1023, W_MIN);
    send_item(MODE_ADD, 10'd1023, 10'd5, W_MAX);
    send_item(MODE_ADD, 10'd5, 10'd0, 16'sd7);
    send_item(MODE_RUN, 10'd1023, 10'd0, 16'sd0);
    send_item(MODE_READ, 10'd0, 10'd0, 16'sd0);
    send_item(MODE_READ, 10'd5, 10'd0, 16'sd0);
    send_item(MODE_READ, 10'd1023, 10'd0, 16'sd0);
    send_item(MODE_READ, 10'd1000, 10'd0, 16'sd0);

    sent = 0;
    session = 0;
    while (sent < RANDOM_ITEMS) begin
      if (session % 4 == 0) begin
        case ($urandom_range(0, 19))
          0: cfg_val = CFG_W'(0);
          1: cfg_val = CFG_W'(2047);
          2: cfg_val = CFG_W'(1024);
          3: cfg_val = CFG_W'($urandom_range(9, 2047));
          default: cfg_val = CFG_W'($urandom_range(1, 8));
        endcase
        set_nodes(cfg_val);
      end
      if (session == 12) begin
        // Hold the result side off while read beats keep coming, so the input backs up.
        drain();
        long_hold = 1'b1;
        steady = 1'b1;
        for (k = 0; k < 16; k++) send_item(MODE_READ, pick_node(live), any_node(), pick_weight());
        sent += 16;
      end
      if (session == 20) drain();
      steady = (session % 9 == 4);
      big = live > 16;
      if (big || $urandom_range(0, 4) != 0) begin
        send_item(MODE_CLEAR, any_node(), any_node(), pick_weight());
        sent++;
      end
      count = big ? $urandom_range(0, 2) : $urandom_range(0, 12);
      for (k = 0; k < count; k++) begin
        send_item(MODE_ADD, pick_node(live), pick_node(live), pick_weight());
        sent++;
      end
      send_item(MODE_RUN, pick_node(live), any_node(), pick_weight());
      sent++;
      if (!big && $urandom_range(0, 2) == 0) begin
        for (k = 0; k < live; k++) send_item(MODE_READ, NODE_W'(k), any_node(), pick_weight());
        sent += live;
      end else begin
        count = $urandom_range(0, 5);
        for (k = 0; k < count; k++) begin
          send_item(MODE_READ, pick_node(live), any_node(), pick_weight());
          sent++;
        end
      end
      count = $urandom_range(0, 2);
      for (k = 0; k < count; k++) begin
        send_item(mode_t'($urandom_range(0, 3)), any_node(), any_node(), WEIGHT_W'($urandom));
        sent++;
      end
      session++;
    end
    steady = 1'b0;

    // Pile up self-loops on the source, deep enough to saturate its distance.
    set_nodes(CFG_W'(1024));
    send_item(MODE_CLEAR, 10'd0, 10'd0, 16'sd0);
    for (k = 0; k < 70; k++) send_item(MODE_ADD, 10'd0, 10'd0, W_MIN);
    send_item(MODE_ADD, 10'd0, 10'd1, W_MAX);
    send_item(MODE_ADD, 10'd1, 10'd2, W_MIN);
    send_item(MODE_ADD, 10'd2, 10'd1023, pick_weight());
    send_item(MODE_ADD, 10'd1023, 10'd5, pick_weight());
    send_item(MODE_RUN, 10'd0, 10'd0, 16'sd0);
    send_item(MODE_READ, 10'd0, 10'd0, 16'sd0);
    send_item(MODE_READ, 10'd1, 10'd0, 16'sd0);
    send_item(MODE_READ, 10'd2, 10'd0, 16'sd0);
    send_item(MODE_READ, 10'd1023, 10'd0, 16'sd0);
    send_item(MODE_READ, 10'd5, 10'd0, 16'sd0);
    send_item(MODE_CLEAR, 10'd0, 10'd0, 16'sd0);
    send_item(MODE_READ, 10'd1, 10'd0, 16'sd0);
    send_item(MODE_RUN, 10'd0, 10'd0, 16'sd0);

    drain();
    repeat (END_CYCLES) @(negedge clk);
    if (mismatch_count == 0 && reports_owed == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
